// ===== design/fbpbe_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpbe_pkg: shared types and constants for the pixel blend engine
// Command record passed from the front end to the back end, register
// indexes, blend mode codes and the exact divide-by-255 helper.
// ----------------------------------------------------------------------------
package fbpbe_pkg;

    // Beat and register widths
    localparam int PIX_W      = 32;
    localparam int COORD_W    = 16;
    localparam int IN_DATA_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 2'd2;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] FB_WIDTH_RST  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] FB_HEIGHT_RST = 9'd256;

    // Blend modes (the unused code behaves as replace)
    localparam logic [1:0] MODE_REPLACE = 2'd0;
    localparam logic [1:0] MODE_TRUNC   = 2'd1;
    localparam logic [1:0] MODE_ROUND   = 2'd2;

    // Request kinds carried on s_tuser
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [15:0] ROUND_BIAS   = 16'd127;

    // What the back end has to do with one beat
    typedef enum logic [1:0] {
        CMD_READ,       // fetch pixel and return it
        CMD_READ_ZERO,  // out of bounds read, return zero
        CMD_WRITE,      // store source pixel as is
        CMD_BLEND       // read, blend, write back
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic             rounded;  // 1: rounded blit blend, 0: truncating blend
        logic [PIX_W-1:0] src;
    } cmd_t;

    // Exact floor(v/255) for v up to 65152: q = (t + (t >> 8)) >> 8, t = v + 1.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        logic [16:0] s;
        t = {1'b0, v} + 17'd1;
        s = t + {8'd0, t[16:8]};
        return s[15:8];
    endfunction

endpackage

// ===== design/fbpbe_ram.sv =====
// ----------------------------------------------------------------------------
// fbpbe_ram: generic simple dual port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module fbpbe_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fbpbe_front.sv =====
// ----------------------------------------------------------------------------
// fbpbe_front: request intake and classification
// Holds the configuration registers, bounds checks the coordinate, forms
// the pixel address and decides what the back end must do with the beat.
// ----------------------------------------------------------------------------
module fbpbe_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [fbpbe_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [fbpbe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_tuser,
    input  logic [fbpbe_pkg::IN_DATA_W-1:0]     s_tdata,
    // back end status
    input  logic                                clear_busy,
    // command queue push side
    input  logic                                q_full,
    output logic                                q_push,
    output fbpbe_pkg::cmd_t                     q_cmd,
    output logic [AW-1:0]                       q_addr
);

    // Clamp limits that fit the 9-bit size registers
    localparam int WCAP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int HCAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

    logic [fbpbe_pkg::CFG_DATA_W-1:0] fb_width_reg;
    logic [fbpbe_pkg::CFG_DATA_W-1:0] fb_height_reg;
    logic [1:0]                       blend_mode_reg;

    logic                             f_valid_reg, f_valid_next;
    fbpbe_pkg::cmd_t                  f_cmd_reg;
    logic [AW-1:0]                    f_addr_reg;

    logic                             accept;
    logic [fbpbe_pkg::COORD_W-1:0]    pos_x;
    logic [fbpbe_pkg::COORD_W-1:0]    pos_y;
    logic [fbpbe_pkg::PIX_W-1:0]      src_pixel;
    logic [8:0]                       eff_w;
    logic [8:0]                       eff_h;
    logic                             in_bounds;
    logic [17:0]                      row_base;
    logic [17:0]                      pix_idx;
    logic                             blend_on;
    logic                             keep;
    fbpbe_pkg::cmd_t                  cls_cmd;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_width_reg   <= fbpbe_pkg::FB_WIDTH_RST;
            fb_height_reg  <= fbpbe_pkg::FB_HEIGHT_RST;
            blend_mode_reg <= fbpbe_pkg::MODE_REPLACE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fbpbe_pkg::CFG_FB_WIDTH:   fb_width_reg   <= cfg_wdata;
                fbpbe_pkg::CFG_FB_HEIGHT:  fb_height_reg  <= cfg_wdata;
                fbpbe_pkg::CFG_BLEND_MODE: blend_mode_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Beat fields
    assign pos_x     = s_tdata[15:0];
    assign pos_y     = s_tdata[31:16];
    assign src_pixel = s_tdata[63:32];

    // Effective size and bounds check
    assign eff_w = (fb_width_reg > 9'(WCAP)) ? 9'(WCAP) : fb_width_reg;
    assign eff_h = (fb_height_reg > 9'(HCAP)) ? 9'(HCAP) : fb_height_reg;
    assign in_bounds = !pos_x[15] && !pos_y[15]
                    && (pos_x[14:0] < {6'd0, eff_w})
                    && (pos_y[14:0] < {6'd0, eff_h});

    // Row-major address y*W + x; only used when in bounds
    assign row_base = {9'd0, pos_y[8:0]} * {9'd0, eff_w};
    assign pix_idx  = row_base + {9'd0, pos_x[8:0]};

    // Classification
    assign blend_on = (blend_mode_reg == fbpbe_pkg::MODE_TRUNC)
                   || (blend_mode_reg == fbpbe_pkg::MODE_ROUND);

    always_comb begin
        keep            = 1'b1;
        cls_cmd.kind    = fbpbe_pkg::CMD_WRITE;
        cls_cmd.rounded = (blend_mode_reg == fbpbe_pkg::MODE_ROUND);
        cls_cmd.src     = src_pixel;
        if (s_tuser == fbpbe_pkg::REQ_READ) begin
            cls_cmd.kind = in_bounds ? fbpbe_pkg::CMD_READ : fbpbe_pkg::CMD_READ_ZERO;
        end else if (!in_bounds) begin
            keep = 1'b0;
        end else if (blend_on && src_pixel[7:0] == fbpbe_pkg::ALPHA_CLEAR) begin
            // transparent source leaves the pixel as it is
            keep = 1'b0;
        end else if (blend_on && src_pixel[7:0] != fbpbe_pkg::ALPHA_OPAQUE) begin
            cls_cmd.kind = fbpbe_pkg::CMD_BLEND;
        end
    end

    // Intake register, drained into the queue
    assign q_push   = f_valid_reg && !q_full;
    assign s_tready = !clear_busy && (!f_valid_reg || !q_full);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = keep;
        end else if (q_push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_cmd_reg  <= cls_cmd;
            f_addr_reg <= AW'(pix_idx);
        end
    end

    assign q_cmd  = f_cmd_reg;
    assign q_addr = f_addr_reg;

endmodule

// ===== design/fbpbe_queue.sv =====
// ----------------------------------------------------------------------------
// fbpbe_queue: small command FIFO between front and back end
// Register based, head entry visible combinationally.
// ----------------------------------------------------------------------------
module fbpbe_queue #(
    parameter int DW    = 40,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] head_data,
    output logic          empty,
    output logic          full
);

    logic [DW-1:0] entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign head_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update, wrapping at DEPTH
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/fbpbe_back.sv =====
// ----------------------------------------------------------------------------
// fbpbe_back: framebuffer access and blend unit
// Owns the pixel RAM, clears it after reset, then executes queued commands
// one at a time: reads, direct writes and read-modify-write blends.
// ----------------------------------------------------------------------------
module fbpbe_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // command queue pop side
    input  logic                         q_empty,
    input  fbpbe_pkg::cmd_t              q_cmd,
    input  logic [AW-1:0]                q_addr,
    output logic                         q_pop,
    output logic                         clear_busy,
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fbpbe_pkg::PIX_W-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_BL_MUL,
        ST_BL_WR
    } state_t;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                clr_addr_reg, clr_addr_next;
    logic                         m_valid_reg, m_valid_next;
    logic [fbpbe_pkg::PIX_W-1:0]  m_data_reg, m_data_next;

    // working command
    logic [AW-1:0]                wk_addr_reg;
    logic [fbpbe_pkg::PIX_W-1:0]  wk_src_reg;
    logic                         wk_round_reg;
    logic [2:0][15:0]             prod_s_reg;
    logic [2:0][15:0]             prod_d_reg;
    logic [15:0]                  prod_a_reg;

    logic                         out_free;
    logic                         ram_wr_en;
    logic [AW-1:0]                ram_wr_addr;
    logic [fbpbe_pkg::PIX_W-1:0]  ram_wr_data;
    logic                         ram_rd_en;
    logic [fbpbe_pkg::PIX_W-1:0]  ram_rd_data;
    logic [7:0]                   src_a;
    logic [7:0]                   inv_a;
    logic [fbpbe_pkg::PIX_W-1:0]  blend_pix;

    fbpbe_ram #(
        .DW    (fbpbe_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_pix_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (q_addr),
        .rd_data (ram_rd_data)
    );

    // Output slot can take a result this cycle
    assign out_free   = !m_valid_reg || m_tready;
    assign clear_busy = (state_reg == ST_CLEAR);

    // Pop the head when idle; a zero read also needs the output slot
    assign q_pop = (state_reg == ST_IDLE) && !q_empty
                && ((q_cmd.kind != fbpbe_pkg::CMD_READ_ZERO) || out_free);
    assign ram_rd_en = q_pop && ((q_cmd.kind == fbpbe_pkg::CMD_READ)
                              || (q_cmd.kind == fbpbe_pkg::CMD_BLEND));

    // Blend datapath, from registered products
    assign src_a = wk_src_reg[7:0];
    assign inv_a = fbpbe_pkg::ALPHA_OPAQUE - src_a;

    always_comb begin
        logic [8:0]  sum_t;
        logic [15:0] sum_r;
        logic [8:0]  alpha_r;
        blend_pix = '0;
        for (int i = 0; i < 3; i++) begin
            sum_t = {1'b0, fbpbe_pkg::div255(prod_s_reg[i])}
                  + {1'b0, fbpbe_pkg::div255(prod_d_reg[i])};
            sum_r = prod_s_reg[i] + prod_d_reg[i] + fbpbe_pkg::ROUND_BIAS;
            blend_pix[8*(i+1) +: 8] = wk_round_reg ? fbpbe_pkg::div255(sum_r) : sum_t[7:0];
        end
        // rounded mode composites alpha, truncating mode keeps source alpha
        alpha_r = {1'b0, src_a} + {1'b0, fbpbe_pkg::div255(prod_a_reg)};
        if (wk_round_reg) begin
            blend_pix[7:0] = alpha_r[8] ? fbpbe_pkg::ALPHA_OPAQUE : alpha_r[7:0];
        end else begin
            blend_pix[7:0] = src_a;
        end
    end

    // RAM write port: clearing pass, direct writes, blend write-back
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = q_addr;
        ram_wr_data = q_cmd.src;
        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
            end
            ST_IDLE: begin
                ram_wr_en = q_pop && (q_cmd.kind == fbpbe_pkg::CMD_WRITE);
            end
            ST_BL_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wk_addr_reg;
                ram_wr_data = blend_pix;
            end
            default: ;
        endcase
    end

    // Sequencer next state
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_pop) begin
                    case (q_cmd.kind)
                        fbpbe_pkg::CMD_READ:  state_next = ST_RD_WAIT;
                        fbpbe_pkg::CMD_BLEND: state_next = ST_BL_MUL;
                        fbpbe_pkg::CMD_READ_ZERO: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = ram_rd_data;
                    state_next   = ST_IDLE;
                end
            end
            ST_BL_MUL: state_next = ST_BL_WR;
            ST_BL_WR:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // Working command capture and blend products
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            wk_addr_reg  <= q_addr;
            wk_src_reg   <= q_cmd.src;
            wk_round_reg <= q_cmd.rounded;
        end
        if (state_reg == ST_BL_MUL) begin
            for (int i = 0; i < 3; i++) begin
                prod_s_reg[i] <= {8'd0, wk_src_reg[8*(i+1) +: 8]} * {8'd0, src_a};
                prod_d_reg[i] <= {8'd0, ram_rd_data[8*(i+1) +: 8]} * {8'd0, inv_a};
            end
            prod_a_reg <= {8'd0, ram_rd_data[7:0]} * {8'd0, inv_a};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!q_pop && !ram_rd_en))
        else $error("command taken during the clearing pass");

    a_blend_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BL_MUL) |=> (state_reg == ST_BL_WR && ram_wr_en))
        else $error("blend did not write back after its multiply step");

    a_read_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |=> (state_reg == ST_RD_WAIT || state_reg == ST_BL_MUL))
        else $error("RAM read issued without a consumer");

endmodule

// ===== design/framebuffer_pixel_blend_engine_unit.sv =====
// ----------------------------------------------------------------------------
// framebuffer_pixel_blend_engine_unit: RGBA8888 framebuffer with blending
// Pixel read/write requests at signed coordinates; writes combine the source
// with the stored pixel by replace, truncating or rounded alpha blend.
//
//   port group   dir  tdata (low bit first)                      tuser
//   s_*          in   pos_x[15:0] pos_y[31:16] src_pixel[63:32]  req_type
//   m_*          out  read_color[31:0]                           -
//   cfg_*        in   wr_en, index 0 width / 1 height / 2 mode, 9-bit data
//
// After reset the pixel RAM is zeroed one entry per cycle, all of its
// MAX_WIDTH*MAX_HEIGHT entries (65536 at defaults); s_tready stays low
// meanwhile. The back end owns the single RAM read and write ports and runs
// one command at a time: a replace write, a read or a blend read-modify-write.
// Dropped writes (out of bounds or transparent source) take no back end time.
// A 4-entry command queue lets intake continue while the back end or m_tready
// stalls; one finished read result waits in the output register.
// ----------------------------------------------------------------------------
module framebuffer_pixel_blend_engine_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [fbpbe_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [fbpbe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,   // req_type
    input  logic [fbpbe_pkg::IN_DATA_W-1:0]   s_tdata,   // pos_x, pos_y, src_pixel
    // read result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fbpbe_pkg::PIX_W-1:0]       m_tdata    // read_color
);

    localparam int DEPTH       = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW          = $bits(fbpbe_pkg::cmd_t);
    localparam int QUEUE_DEPTH = 4;

    logic                  clear_busy;
    logic                  f_push;
    fbpbe_pkg::cmd_t       f_cmd;
    logic [AW-1:0]         f_addr;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic [AW+CW-1:0]      q_head;
    fbpbe_pkg::cmd_t       q_cmd;
    logic [AW-1:0]         q_addr;

    fbpbe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .clear_busy (clear_busy),
        .q_full     (q_full),
        .q_push     (f_push),
        .q_cmd      (f_cmd),
        .q_addr     (f_addr)
    );

    fbpbe_queue #(
        .DW    (AW + CW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data ({f_addr, f_cmd}),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign q_cmd  = fbpbe_pkg::cmd_t'(q_head[CW-1:0]);
    assign q_addr = q_head[AW+CW-1:CW];

    fbpbe_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_cmd      (q_cmd),
        .q_addr     (q_addr),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
